### rtl/core/ubds_pkg.sv
// ----------------------------------------------------------------------------
// ubds_pkg
// Shared widths and constants for the UART baud divisor search.
// ----------------------------------------------------------------------------
package ubds_pkg;

  localparam int CLK_W   = 26;  // reference clock register
  localparam int BAUD_W  = 26;  // requested baud rate
  localparam int OSC_W   = 6;   // oversampling factor
  localparam int DIV_W   = 26;  // quotient / reported divisor
  localparam int CAND_W  = DIV_W + 1;      // nominal + 1 may carry out
  localparam int PROD_W  = OSC_W + CAND_W; // osc * candidate
  localparam int CNT_W   = $clog2(DIV_W);
  localparam int ERR_W   = DIV_W + 7;      // error scaled by 100

  localparam int MAX_OVERSAMPLE_DEF = 32;
  localparam logic [CLK_W-1:0] CLOCK_RESET = CLK_W'(40000000);
  localparam logic [6:0] ERR_SCALE = 7'd100;
  localparam logic [2:0] TOL_SCALE = 3'd5;

  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] REG_CLOCK_HZ = 3'h0;

endpackage

### rtl/core/ubds_div.sv
// ----------------------------------------------------------------------------
// ubds_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ubds_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start_i,
  input  logic [ubds_pkg::CLK_W-1:0]       dividend_i,
  input  logic [ubds_pkg::PROD_W-1:0]      divisor_i,
  output logic                             done_o,
  output logic [ubds_pkg::DIV_W-1:0]       quotient_o
);

  logic                            busy_r;
  logic                            done_r;
  logic [ubds_pkg::CNT_W-1:0]      cnt_r;
  logic [ubds_pkg::PROD_W-1:0]     rem_r;
  logic [ubds_pkg::PROD_W-1:0]     rem_nxt;
  logic [ubds_pkg::PROD_W-1:0]     dsr_r;
  logic [ubds_pkg::DIV_W-1:0]      quo_r;
  logic [ubds_pkg::PROD_W:0]       trial;
  logic [ubds_pkg::PROD_W:0]       diff;
  logic                            qbit;

  // shift the next dividend bit into the partial remainder
  assign trial   = {rem_r, quo_r[ubds_pkg::DIV_W-1]};
  assign diff    = trial - {1'b0, dsr_r};
  assign qbit    = (trial >= {1'b0, dsr_r});
  assign rem_nxt = qbit ? diff[ubds_pkg::PROD_W-1:0] : trial[ubds_pkg::PROD_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ubds_pkg::CNT_W'(ubds_pkg::DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // dividend bits leave from the top of quo_r as quotient bits enter below
  always_ff @(posedge clk) begin
    if (start_i) begin
      rem_r <= '0;
      quo_r <= ubds_pkg::DIV_W'(dividend_i);
      dsr_r <= divisor_i;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[ubds_pkg::DIV_W-2:0], qbit};
    end
  end

  assign done_o     = done_r;
  assign quotient_o = quo_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a running division");

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !start_i |=> busy_r || done_r)
    else $error("division dropped before completion");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !start_i |=> (rem_r < dsr_r) || dsr_r == '0)
    else $error("partial remainder out of range");

endmodule

### rtl/core/uart_baud_divisor_search.sv
// ----------------------------------------------------------------------------
// uart_baud_divisor_search
// From acceptance to out_valid: a zero baud rate goes to the result with no
// division; otherwise each oversampling factor, from MAX_OVERSAMPLE down to 1,
// takes up to 4 divisions (the nominal divisor, then up to 3 candidates), and a
// result also waits while a previous one sits stalled. Throughput: one transaction at a
// time, set by the bit-serial divider (26 quotient bits, one per cycle).
// Reset: synchronous, active low; clock_hz returns to 40000000, no result.
// ----------------------------------------------------------------------------
module uart_baud_divisor_search #(
  parameter int MAX_OVERSAMPLE = ubds_pkg::MAX_OVERSAMPLE_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ubds_pkg::BAUD_W-1:0]         in_baud_rate,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ubds_pkg::OSC_W-1:0]          out_oversample,
  output logic [ubds_pkg::DIV_W-1:0]          out_divisor,
  output logic                                out_found,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [ubds_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [31:0]                         cfg_pwdata,
  output logic [31:0]                         cfg_prdata,
  output logic                                cfg_pready
);

  typedef enum logic [5:0] {
    ST_IDLE       = 6'b000001,
    ST_NOM_START  = 6'b000010,
    ST_NOM_WAIT   = 6'b000100,
    ST_CAND_START = 6'b001000,
    ST_CAND_WAIT  = 6'b010000,
    ST_FINISH     = 6'b100000
  } state_t;

  localparam logic [ubds_pkg::OSC_W-1:0] OSC_TOP = ubds_pkg::OSC_W'(MAX_OVERSAMPLE);

  state_t                          state_r, state_nxt;
  logic [ubds_pkg::CLK_W-1:0]      clock_hz_r;
  logic [ubds_pkg::BAUD_W-1:0]     baud_r, baud_nxt;
  logic [ubds_pkg::OSC_W-1:0]      osc_r, osc_nxt;
  logic [1:0]                      k_r, k_nxt;
  logic [ubds_pkg::DIV_W-1:0]      nom_r, nom_nxt;
  logic [ubds_pkg::OSC_W-1:0]      res_osc_r, res_osc_nxt;
  logic [ubds_pkg::DIV_W-1:0]      res_div_r, res_div_nxt;
  logic                            res_found_r, res_found_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [ubds_pkg::OSC_W-1:0]      out_osc_r, out_osc_nxt;
  logic [ubds_pkg::DIV_W-1:0]      out_div_r, out_div_nxt;
  logic                            out_found_r, out_found_nxt;

  logic                            in_acc;
  logic                            cfg_wr;
  logic [ubds_pkg::CAND_W-1:0]     cand;
  logic [ubds_pkg::CAND_W-1:0]     mul_b;
  logic [ubds_pkg::PROD_W-1:0]     prod;
  logic                            div_start;
  logic                            div_done;
  logic [ubds_pkg::DIV_W-1:0]      quot;
  logic [ubds_pkg::DIV_W-1:0]      err;
  logic [ubds_pkg::ERR_W-1:0]      err_scaled;
  logic [ubds_pkg::ERR_W-1:0]      tol_scaled;
  logic                            pass;

  assign in_stall   = (state_r != ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  assign cfg_prdata = (cfg_paddr == ubds_pkg::REG_CLOCK_HZ) ? 32'(clock_hz_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r <= ubds_pkg::CLOCK_RESET;
    end else if (cfg_wr && cfg_paddr == ubds_pkg::REG_CLOCK_HZ) begin
      clock_hz_r <= cfg_pwdata[ubds_pkg::CLK_W-1:0];
    end
  end

  // candidate = nominal - 1 + k
  assign cand  = {1'b0, nom_r} + ubds_pkg::CAND_W'(k_r) - ubds_pkg::CAND_W'(1);
  assign mul_b = (state_r == ST_NOM_START) ? ubds_pkg::CAND_W'(baud_r) : cand;
  assign prod  = ubds_pkg::PROD_W'(osc_r) * ubds_pkg::PROD_W'(mul_b);

  assign div_start = (state_r == ST_NOM_START) ||
                     (state_r == ST_CAND_START && cand != '0);

  ubds_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (div_start),
    .dividend_i (clock_hz_r),
    .divisor_i  (prod),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  // within 5 percent: |actual - baud| * 100 < baud * 5
  assign err        = (quot > baud_r) ? quot - baud_r : baud_r - quot;
  assign err_scaled = ubds_pkg::ERR_W'(err) * ubds_pkg::ERR_W'(ubds_pkg::ERR_SCALE);
  assign tol_scaled = ubds_pkg::ERR_W'(baud_r) * ubds_pkg::ERR_W'(ubds_pkg::TOL_SCALE);
  assign pass       = (err_scaled < tol_scaled);

  always_comb begin
    state_nxt     = state_r;
    baud_nxt      = baud_r;
    osc_nxt       = osc_r;
    k_nxt         = k_r;
    nom_nxt       = nom_r;
    res_osc_nxt   = res_osc_r;
    res_div_nxt   = res_div_r;
    res_found_nxt = res_found_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_osc_nxt   = out_osc_r;
    out_div_nxt   = out_div_r;
    out_found_nxt = out_found_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          baud_nxt      = in_baud_rate;
          osc_nxt       = OSC_TOP;
          res_osc_nxt   = '0;
          res_div_nxt   = '0;
          res_found_nxt = 1'b0;
          state_nxt     = (in_baud_rate == '0) ? ST_FINISH : ST_NOM_START;
        end
      end
      ST_NOM_START: begin
        state_nxt = ST_NOM_WAIT;
      end
      ST_NOM_WAIT: begin
        if (div_done) begin
          nom_nxt = quot;
          k_nxt   = '0;
          if (quot != '0) begin
            state_nxt = ST_CAND_START;
          end else if (osc_r == ubds_pkg::OSC_W'(1)) begin
            state_nxt = ST_FINISH;
          end else begin
            osc_nxt   = osc_r - 1'b1;
            state_nxt = ST_NOM_START;
          end
        end
      end
      ST_CAND_START: begin
        // a zero candidate only occurs for nominal 1, first try
        if (cand == '0) begin
          k_nxt = k_r + 1'b1;
        end else begin
          state_nxt = ST_CAND_WAIT;
        end
      end
      ST_CAND_WAIT: begin
        if (div_done) begin
          if (pass) begin
            res_osc_nxt   = osc_r;
            res_div_nxt   = cand[ubds_pkg::DIV_W-1:0];
            res_found_nxt = 1'b1;
            state_nxt     = ST_FINISH;
          end else if (k_r != 2'd2) begin
            k_nxt     = k_r + 1'b1;
            state_nxt = ST_CAND_START;
          end else if (osc_r == ubds_pkg::OSC_W'(1)) begin
            state_nxt = ST_FINISH;
          end else begin
            osc_nxt   = osc_r - 1'b1;
            state_nxt = ST_NOM_START;
          end
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_osc_nxt   = res_osc_r;
          out_div_nxt   = res_div_r;
          out_found_nxt = res_found_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    baud_r      <= baud_nxt;
    osc_r       <= osc_nxt;
    k_r         <= k_nxt;
    nom_r       <= nom_nxt;
    res_osc_r   <= res_osc_nxt;
    res_div_r   <= res_div_nxt;
    res_found_r <= res_found_nxt;
    out_osc_r   <= out_osc_nxt;
    out_div_r   <= out_div_nxt;
    out_found_r <= out_found_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_oversample = out_osc_r;
  assign out_divisor    = out_div_r;
  assign out_found      = out_found_r;

  a_found_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_found_r |-> out_osc_r != '0 && out_div_r != '0)
    else $error("found result with a zero field");

  a_miss_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_osc_r == '0 && out_div_r == '0)
    else $error("missed search reports nonzero fields");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_NOM_WAIT || state_r == ST_CAND_WAIT)
    else $error("division finished outside a wait state");

  a_osc_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_NOM_START |-> osc_r != '0 && osc_r <= OSC_TOP)
    else $error("oversampling factor out of range");

  a_cand_k: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CAND_START || state_r == ST_CAND_WAIT |-> k_r != 2'd3)
    else $error("candidate index overran");

endmodule
